// ===== rtl/sstk_pkg.sv =====
// Shared types and constants for the segmented stack block.
// No dependencies; imported by sstk_ctrl, the top level and the testbench.
package sstk_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_PUSH   = 2'd0;
  localparam cmd_t CMD_POP    = 2'd1;
  localparam cmd_t CMD_POP_AT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  localparam logic signed [31:0] EMPTY_MARK   = -32'sd217;
  localparam logic [4:0]         CAP_RESET    = 5'd3;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] push_value;
    logic [3:0]         segment_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    status_t            status;
    logic [4:0]         segments_in_use;
  } out_item_t;

  // Per-request outcome handed from the control logic to the result stage.
  typedef struct packed {
    status_t    status;
    logic       use_mem;
    logic       empty_mark;
    logic [4:0] segs;
  } step_res_t;

endpackage

// ===== rtl/sstk_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module sstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sstk_ctrl.sv =====
// Segment bookkeeping: capacity register, per-segment fill counts, chain length,
// and entry memory addressing. Depends on sstk_pkg.
module sstk_ctrl #(
  parameter int MAX_SEGMENTS  = 16,
  parameter int SEGMENT_DEPTH = 16,
  localparam int ADDR_W = (MAX_SEGMENTS * SEGMENT_DEPTH > 1) ?
                          $clog2(MAX_SEGMENTS * SEGMENT_DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_data,
  input  sstk_pkg::in_item_t  item,
  input  logic                adv,
  output sstk_pkg::step_res_t res,
  output logic                mem_we,
  output logic                mem_re,
  output logic [ADDR_W-1:0]   mem_addr
);
  import sstk_pkg::*;

  localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int TOT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int FILL_W = $clog2(SEGMENT_DEPTH + 1);
  localparam int DEP_W  = (SEGMENT_DEPTH > 1) ? $clog2(SEGMENT_DEPTH) : 1;
  localparam int CW     = (FILL_W > 5) ? FILL_W : 5;
  localparam int IW     = (TOT_W > 4) ? TOT_W : 4;

  logic [4:0]        cap_r;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [FILL_W-1:0] fill_r [MAX_SEGMENTS];

  logic [CW-1:0]     cap_c, f_c;
  logic [IW-1:0]     idx_w, tot_w;
  logic [SEG_W-1:0]  top, far_seg, sel_seg;
  logic [FILL_W-1:0] sel_fill;
  logic              pop_at_far, bad_idx, open_new;

  logic              fill_we;
  logic [SEG_W-1:0]  fill_widx;
  logic [FILL_W-1:0] fill_wdata;
  logic [SEG_W-1:0]  acc_seg;
  logic [DEP_W-1:0]  acc_off;
  logic              wr, rd;
  status_t           st;
  logic              mark;

  // Effective capacity: zero reads as one, saturate at the segment depth.
  always_comb begin
    cap_c = (cap_r == 5'd0) ? CW'(1) : CW'(cap_r);
    if (cap_c > CW'(SEGMENT_DEPTH)) begin
      cap_c = CW'(SEGMENT_DEPTH);
    end
  end

  assign idx_w      = IW'(item.segment_index);
  assign tot_w      = IW'(total_r);
  assign top        = SEG_W'(total_r - TOT_W'(1));
  assign far_seg    = SEG_W'(tot_w - IW'(1) - idx_w);
  assign pop_at_far = (item.cmd == CMD_POP_AT) && (item.segment_index != 4'd0);
  assign bad_idx    = idx_w >= tot_w;
  assign sel_seg    = pop_at_far ? far_seg : top;
  assign sel_fill   = (32'(sel_seg) < MAX_SEGMENTS) ? fill_r[sel_seg] : '0;
  assign f_c        = CW'(sel_fill);
  assign open_new   = (total_r == '0) || (f_c >= cap_c);

  always_comb begin
    total_nxt  = total_r;
    fill_we    = 1'b0;
    fill_widx  = sel_seg;
    fill_wdata = sel_fill;
    acc_seg    = sel_seg;
    acc_off    = DEP_W'(sel_fill - FILL_W'(1));
    wr         = 1'b0;
    rd         = 1'b0;
    st         = ST_OK;
    mark       = 1'b0;
    unique case (item.cmd)
      CMD_PUSH: begin
        if (open_new) begin
          if (total_r == TOT_W'(MAX_SEGMENTS)) begin
            st = ST_FULL;
          end else begin
            acc_seg    = SEG_W'(total_r);
            acc_off    = '0;
            fill_we    = 1'b1;
            fill_widx  = SEG_W'(total_r);
            fill_wdata = FILL_W'(1);
            total_nxt  = total_r + TOT_W'(1);
            wr         = 1'b1;
          end
        end else begin
          acc_seg    = top;
          acc_off    = DEP_W'(sel_fill);
          fill_we    = 1'b1;
          fill_widx  = top;
          fill_wdata = sel_fill + FILL_W'(1);
          wr         = 1'b1;
        end
      end
      CMD_POP, CMD_POP_AT: begin
        if (pop_at_far) begin
          if (bad_idx) begin
            st = ST_BAD_INDEX;
          end else if (sel_fill == '0) begin
            st   = ST_EMPTY;
            mark = 1'b1;
          end else begin
            fill_we    = 1'b1;
            fill_wdata = sel_fill - FILL_W'(1);
            rd         = 1'b1;
          end
        end else if (total_r == '0) begin
          st   = ST_EMPTY;
          mark = 1'b1;
        end else if (sel_fill == '0) begin
          // empty top segment is dropped
          st        = ST_EMPTY;
          mark      = 1'b1;
          total_nxt = total_r - TOT_W'(1);
        end else begin
          fill_we    = 1'b1;
          fill_wdata = sel_fill - FILL_W'(1);
          rd         = 1'b1;
          if (sel_fill == FILL_W'(1)) begin
            total_nxt = total_r - TOT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_addr = ADDR_W'(acc_seg) * ADDR_W'(SEGMENT_DEPTH) + ADDR_W'(acc_off);
  assign mem_we   = adv & wr;
  assign mem_re   = adv & rd;

  assign res.status     = st;
  assign res.use_mem    = rd;
  assign res.empty_mark = mark;
  assign res.segs       = 5'(total_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      total_r <= '0;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (adv) begin
        total_r <= total_nxt;
        if (fill_we) begin
          fill_r[fill_widx] <= fill_wdata;
        end
      end
    end
  end

endmodule

// ===== rtl/segmented_stack_with_pop_at.sv =====
// Top level of the segmented stack: request register, result register,
// entry memory. Depends on sstk_pkg, sstk_ctrl, sstk_ram.
//
// A stack kept as a chain of up to MAX_SEGMENTS segments of at most the
// configured capacity (clamped to 1..SEGMENT_DEPTH) each. Requests are push,
// pop and pop-at (pop from the segment a given distance below the top); every
// request yields exactly one result. A request is taken every cycle when the
// result side keeps up. An accepted request waits in the request register;
// when it advances, the result register and the entry memory's registered read
// load together, and the result is then offered.
// Write the capacity only while no request is in flight.
module segmented_stack_with_pop_at #(
  parameter int MAX_SEGMENTS  = 16,
  parameter int SEGMENT_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  sstk_pkg::in_item_t  in_payload,
  output logic                out_valid,
  input  logic                out_ready,
  output sstk_pkg::out_item_t out_payload
);
  import sstk_pkg::*;

  localparam int DEPTH  = MAX_SEGMENTS * SEGMENT_DEPTH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic      s1_v_r;
  in_item_t  s1_item_r;
  logic      s2_v_r;
  step_res_t s2_res_r;

  step_res_t          res;
  logic               adv, s2_free;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_addr;
  logic [31:0]        mem_rdata;

  assign cfg_ready = 1'b1;
  assign s2_free   = !s2_v_r || out_ready;
  assign adv       = s1_v_r && s2_free;
  assign in_ready  = !s1_v_r || adv;

  sstk_ctrl #(
    .MAX_SEGMENTS  (MAX_SEGMENTS),
    .SEGMENT_DEPTH (SEGMENT_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .item     (s1_item_r),
    .adv      (adv),
    .res      (res),
    .mem_we   (mem_we),
    .mem_re   (mem_re),
    .mem_addr (mem_addr)
  );

  // Read data holds while the result waits: reads fire only on advance.
  sstk_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (s1_item_r.push_value),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_free) begin
        s2_v_r <= adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_payload;
    end
    if (adv) begin
      s2_res_r <= res;
    end
  end

  assign out_valid = s2_v_r;

  always_comb begin
    out_payload.status          = s2_res_r.status;
    out_payload.segments_in_use = s2_res_r.segs;
    if (s2_res_r.use_mem) begin
      out_payload.popped_value = mem_rdata;
    end else if (s2_res_r.empty_mark) begin
      out_payload.popped_value = EMPTY_MARK;
    end else begin
      out_payload.popped_value = '0;
    end
  end

endmodule

// ===== tb/segmented_stack_with_pop_at_tb.sv =====
// Self-checking testbench for segmented_stack_with_pop_at: push, pop and pop-at
// requests under random idling on both sides. Depends on sstk_pkg and the RTL.
`timescale 1ns / 100ps

module segmented_stack_with_pop_at_tb;
  import sstk_pkg::*;

  localparam int MAX_SEG = 16;
  localparam int SEG_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam cmd_t CMD_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [4:0] cfg_data;
  logic in_valid;
  logic in_ready;
  in_item_t in_payload;
  logic out_valid;
  logic out_ready;
  out_item_t out_payload;

  segmented_stack_with_pop_at #(
    .MAX_SEGMENTS(MAX_SEG),
    .SEGMENT_DEPTH(SEG_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_payload(in_payload),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_payload(out_payload)
  );

  // Stack model state
  logic signed [31:0] stack_mem [MAX_SEG][SEG_DEPTH];
  int seg_fill [MAX_SEG];
  int seg_count;
  logic [4:0] cap_reg;

  out_item_t awaited_results[$];
  int error_count;
  int sent_count;
  int checked_count;
  int cfg_count;
  int status_seen [4];
  int cycle_count;
  bit steady_flow;
  int ready_hold;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, awaited_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic status_t take_entry(int seg, output logic signed [31:0] v);
    if (seg_fill[seg] == 0) begin
      v = EMPTY_MARK;
      return ST_EMPTY;
    end
    seg_fill[seg]--;
    v = stack_mem[seg][seg_fill[seg]];
    return ST_OK;
  endfunction

  // top segment is dropped once it is empty, even if it was already empty
  function automatic status_t pop_top(output logic signed [31:0] v);
    int top;
    status_t st;
    if (seg_count == 0) begin
      v = EMPTY_MARK;
      return ST_EMPTY;
    end
    top = seg_count - 1;
    st = take_entry(top, v);
    if (seg_fill[top] == 0) seg_count = top;
    return st;
  endfunction

  function automatic out_item_t apply_stack_op(in_item_t req);
    out_item_t r;
    int cap_eff;
    int top;
    logic signed [31:0] v;
    r.popped_value = '0;
    r.status = ST_OK;
    cap_eff = (cap_reg == 0) ? 1 : (cap_reg > SEG_DEPTH) ? SEG_DEPTH : int'(cap_reg);
    case (req.cmd)
      CMD_PUSH: begin
        if (seg_count == 0 || seg_fill[seg_count - 1] >= cap_eff) begin
          if (seg_count >= MAX_SEG) begin
            r.status = ST_FULL;
          end else begin
            seg_fill[seg_count] = 0;
            seg_count++;
          end
        end
        if (r.status == ST_OK) begin
          top = seg_count - 1;
          stack_mem[top][seg_fill[top]] = req.push_value;
          seg_fill[top]++;
        end
      end
      CMD_POP: begin
        r.status = pop_top(v);
        r.popped_value = v;
      end
      CMD_POP_AT: begin
        if (req.segment_index == 0) begin
          r.status = pop_top(v);
          r.popped_value = v;
        end else if (int'(req.segment_index) >= seg_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.status = take_entry(seg_count - 1 - int'(req.segment_index), v);
          r.popped_value = v;
        end
      end
      default: begin
      end
    endcase
    r.segments_in_use = seg_count[4:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_req(in_item_t item);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_results.push_back(apply_stack_op(item));
    sent_count++;
  endtask

  task automatic send_op(cmd_t cmd, logic signed [31:0] value, logic [3:0] idx);
    in_item_t item;
    item.cmd = cmd;
    item.push_value = value;
    item.segment_index = idx;
    send_req(item);
  endtask

  // results may trail the last acceptance; let the pipeline empty before a write
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_reg = value;
    cfg_count++;
  endtask

  function automatic in_item_t random_req(int push_pct, int popat_pct);
    in_item_t r;
    int roll;
    roll = $urandom_range(0, 99);
    r.segment_index = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0: r.push_value = 32'sh8000_0000;
      1: r.push_value = 32'sh7fff_ffff;
      default: r.push_value = $urandom;
    endcase
    if (roll < 3) begin
      r.cmd = CMD_UNUSED;
    end else if (roll < 3 + push_pct) begin
      r.cmd = CMD_PUSH;
    end else if (roll < 3 + push_pct + popat_pct) begin
      r.cmd = CMD_POP_AT;
      // mostly aim inside the chain so pop-at reaches real segments
      if (seg_count > 0 && $urandom_range(0, 3) != 0)
        r.segment_index = 4'($urandom_range(0, seg_count - 1));
    end else begin
      r.cmd = CMD_POP;
    end
    return r;
  endfunction

  task automatic run_mix(int n, int push_pct, int popat_pct);
    repeat (n) send_req(random_req(push_pct, popat_pct));
  endtask

  // Result side: a random stall before each result (none in steady flow), or a long hold when requested
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 3);
      if (ready_hold > 0) begin
        stall = ready_hold;
        ready_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        flag_error($sformatf("unexpected result value %0d status %0d segs %0d",
                             out_payload.popped_value, out_payload.status,
                             out_payload.segments_in_use));
      end else begin
        want = awaited_results.pop_front();
        if (out_payload.popped_value !== want.popped_value ||
            out_payload.status !== want.status ||
            out_payload.segments_in_use !== want.segments_in_use)
          flag_error($sformatf(
            {"result %0d: expected value %0d status %0d segs %0d, ",
             "got value %0d status %0d segs %0d"},
            checked_count, want.popped_value, want.status, want.segments_in_use,
            out_payload.popped_value, out_payload.status, out_payload.segments_in_use));
        status_seen[want.status]++;
        checked_count++;
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // Empty chain, bad index and the unused command at the reset capacity
  task automatic test_empty_edges();
    send_op(CMD_POP, 32'sd0, 4'd0);
    send_op(CMD_POP_AT, 32'sd0, 4'd0);
    send_op(CMD_POP_AT, 32'sd0, 4'd15);
    send_op(CMD_UNUSED, 32'sh7fff_ffff, 4'd15);
  endtask

  // One entry per segment (capacity 0 acts as 1): fill the chain, overflow,
  // empty a lower segment, then pop through an empty top segment
  task automatic test_full_chain();
    logic signed [31:0] v;
    write_capacity(5'd0);
    for (int i = 0; i < MAX_SEG; i++) begin
      case (i)
        0: v = 32'sh8000_0000;
        1: v = 32'sh7fff_ffff;
        2: v = -32'sd1;
        3: v = 32'sd0;
        default: v = $urandom;
      endcase
      send_op(CMD_PUSH, v, 4'd0);
    end
    send_op(CMD_PUSH, 32'sd12345, 4'd0);
    send_op(CMD_POP_AT, 32'sd0, 4'd1);
    send_op(CMD_POP_AT, 32'sd0, 4'd1);
    send_op(CMD_POP, 32'sd0, 4'd0);
    send_op(CMD_POP, 32'sd0, 4'd0);
    send_op(CMD_POP_AT, 32'sd0, 4'd14);
    send_op(CMD_POP_AT, 32'sd0, 4'd0);
  endtask

  task automatic test_mixed_default();
    write_capacity(CAP_RESET);
    run_mix(250, 55, 20);
  endtask

  // Deep segments filled while the result side holds off for a long stretch
  task automatic test_fill_under_backpressure();
    write_capacity(5'd16);
    ready_hold = 150;
    run_mix(330, 90, 4);
  endtask

  task automatic test_drain();
    run_mix(300, 15, 40);
  endtask

  // capacity above the segment depth saturates
  task automatic test_saturated_capacity();
    write_capacity(5'd31);
    run_mix(250, 60, 20);
  endtask

  task automatic test_single_entry_segments();
    write_capacity(5'd1);
    run_mix(100, 85, 5);
    run_mix(100, 20, 60);
  endtask

  task automatic test_steady_stream();
    write_capacity(5'd7);
    steady_flow = 1'b1;
    run_mix(250, 50, 25);
    steady_flow = 1'b0;
  endtask

  task automatic test_two_entry_segments();
    write_capacity(5'd2);
    run_mix(270, 50, 30);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_payload <= '0;
    cap_reg = CAP_RESET;
    seg_count = 0;
    foreach (seg_fill[i]) seg_fill[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_edges();
    test_full_chain();
    test_mixed_default();
    test_fill_under_backpressure();
    test_drain();
    test_saturated_capacity();
    test_single_entry_segments();
    test_steady_stream();
    test_two_entry_segments();

    in_valid <= 1'b0;
    for (int k = 0; k < 2000 && awaited_results.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (awaited_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", awaited_results.size()));

    $display("Sent %0d requests over %0d capacity writes, checked %0d results",
             sent_count, cfg_count, checked_count);
    $display("Status mix ok/empty/full/bad index: %0d/%0d/%0d/%0d, errors %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_BAD_INDEX], error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
